/* hdl/stpc_pkg.sv */
// Shared types, codes and constants for the s-expression tokenizer with paren check.
// Used by the front lexer, the result queue, the back serializer and the checker.
package stpc_pkg;

  localparam int unsigned MAX_DEPTH_DEF  = 255;
  localparam int unsigned POS_WIDTH_DEF  = 16;
  localparam int unsigned MAX_RES        = 4;
  localparam int unsigned RES_IDX_W      = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W      = $clog2(MAX_RES + 1);
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  localparam logic [2:0] EV_CHAR     = 3'd0;
  localparam logic [2:0] EV_END      = 3'd1;
  localparam logic [2:0] EV_PASS     = 3'd2;
  localparam logic [2:0] EV_UNEXP    = 3'd3;
  localparam logic [2:0] EV_MISSING  = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;
  localparam logic [1:0] KIND_STRING = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_ATOM    = 4'b0010,
    MODE_STRING  = 4'b0100,
    MODE_COMMENT = 4'b1000
  } stpc_mode_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLOSE = 2'd1,
    ERR_DEPTH = 2'd2
  } stpc_err_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } stpc_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  char_out;
    logic [1:0]  token_kind;
    logic [15:0] line_no;
    logic [15:0] column_no;
    logic        last_result;
  } stpc_res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]          cnt;
    stpc_res_t [MAX_RES-1:0]       res;
  } stpc_bundle_t;

  function automatic stpc_res_t mk_res(logic [2:0] ev, logic [7:0] ch, logic [1:0] kind,
                                       logic [15:0] line, logic [15:0] col);
    stpc_res_t r;
    r.event_res   = ev;
    r.char_out    = ch;
    r.token_kind  = kind;
    r.line_no     = line;
    r.column_no   = col;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/stpc_front.sv */
// Front lexer: accepts bytes, tracks position, mode and paren depth,
// and builds the bundle of results that each byte causes. Depends on stpc_pkg.
module stpc_front #(
  parameter int unsigned MAX_DEPTH = stpc_pkg::MAX_DEPTH_DEF,
  parameter int unsigned POS_WIDTH = stpc_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  stpc_pkg::stpc_in_t   data_i,
  output logic                 push_o,
  output stpc_pkg::stpc_bundle_t bundle_o
);
  import stpc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  stpc_mode_e           mode_q, mode_d;
  logic                 dig_q, dig_d;
  logic [POS_WIDTH-1:0] cl_q, cl_d, cc_q, cc_d, sl_q, sl_d, sc_q, sc_d;
  logic [POS_WIDTH-1:0] ol_q, ol_d, oc_q, oc_d, el_q, el_d, ec_q, ec_d;
  logic [DW-1:0]        depth_q, depth_d;
  stpc_err_e            err_q, err_d;

  logic [7:0]           c;
  logic                 sp, dg, opn, cls;
  logic [RES_CNT_W-1:0] n;
  stpc_res_t [MAX_RES-1:0] res;

  always_comb begin
    c   = data_i.char_in;
    sp  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    dg  = (c >= CH_ZERO) && (c <= CH_NINE);
    opn = (c == CH_OPEN);
    cls = (c == CH_CLOSE);
    n   = '0;
    res = '0;
    mode_d  = mode_q;
    dig_d   = dig_q;
    cl_d    = cl_q;
    cc_d    = cc_q;
    sl_d    = sl_q;
    sc_d    = sc_q;
    ol_d    = ol_q;
    oc_d    = oc_q;
    el_d    = el_q;
    ec_d    = ec_q;
    depth_d = depth_q;
    err_d   = err_q;

    if (mode_d == MODE_ATOM && (sp || opn || cls)) begin
      res[n[RES_IDX_W-1:0]] = mk_res(EV_END, 8'd0, dig_d ? KIND_NUMBER : KIND_IDENT,
                                     16'(sl_d), 16'(sc_d));
      n = n + 1'b1;
      mode_d = MODE_IDLE;
    end

    unique case (mode_d)
      MODE_ATOM: begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_CHAR, c, KIND_IDENT, 16'(sl_d), 16'(sc_d));
        n = n + 1'b1;
        if (!dg) dig_d = 1'b0;
      end
      MODE_STRING: begin
        if (c == CH_DQUOTE) begin
          res[n[RES_IDX_W-1:0]] = mk_res(EV_END, 8'd0, KIND_STRING, 16'(sl_d), 16'(sc_d));
          mode_d = MODE_IDLE;
        end else begin
          res[n[RES_IDX_W-1:0]] = mk_res(EV_CHAR, c, KIND_IDENT, 16'(sl_d), 16'(sc_d));
        end
        n = n + 1'b1;
      end
      MODE_COMMENT: begin
        if (c == CH_NL) mode_d = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (!sp) begin
          sl_d = cl_q;
          sc_d = cc_q;
          if (opn || cls || c == CH_SQUOTE) begin
            res[n[RES_IDX_W-1:0]] = mk_res(EV_CHAR, c, KIND_IDENT, 16'(sl_d), 16'(sc_d));
            n = n + 1'b1;
            res[n[RES_IDX_W-1:0]] = mk_res(EV_END, 8'd0,
                                           (c == CH_SQUOTE) ? KIND_IDENT : KIND_SYMBOL,
                                           16'(sl_d), 16'(sc_d));
            n = n + 1'b1;
            if (err_d == ERR_NONE && opn) begin
              if (depth_d >= DEPTH_MAX) begin
                err_d = ERR_DEPTH;
                el_d  = cl_q;
                ec_d  = cc_q;
              end else begin
                if (depth_d == '0) begin
                  ol_d = cl_q;
                  oc_d = cc_q;
                end
                depth_d = depth_d + 1'b1;
              end
            end else if (err_d == ERR_NONE && cls) begin
              if (depth_d == '0) begin
                err_d = ERR_CLOSE;
                el_d  = cl_q;
                ec_d  = cc_q;
              end else begin
                depth_d = depth_d - 1'b1;
              end
            end
          end else if (c == CH_SEMI) begin
            mode_d = MODE_COMMENT;
          end else if (c == CH_DQUOTE) begin
            mode_d = MODE_STRING;
          end else begin
            mode_d = MODE_ATOM;
            dig_d  = dg;
            res[n[RES_IDX_W-1:0]] = mk_res(EV_CHAR, c, KIND_IDENT, 16'(sl_d), 16'(sc_d));
            n = n + 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (c == CH_NL) begin
      if (cl_q != POS_MAX) cl_d = cl_q + 1'b1;
      cc_d = POS_ONE;
    end else if (cc_q != POS_MAX) begin
      cc_d = cc_q + 1'b1;
    end

    if (data_i.end_of_text) begin
      if (mode_d == MODE_ATOM) begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_END, 8'd0, dig_d ? KIND_NUMBER : KIND_IDENT,
                                       16'(sl_d), 16'(sc_d));
        n = n + 1'b1;
      end else if (mode_d == MODE_STRING) begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_END, 8'd0, KIND_STRING, 16'(sl_d), 16'(sc_d));
        n = n + 1'b1;
      end
      if (err_d == ERR_CLOSE) begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_UNEXP, 8'd0, KIND_IDENT, 16'(el_d), 16'(ec_d));
      end else if (err_d == ERR_DEPTH) begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_OVERFLOW, 8'd0, KIND_IDENT, 16'(el_d), 16'(ec_d));
      end else if (depth_d != '0) begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_MISSING, 8'd0, KIND_IDENT, 16'(ol_d), 16'(oc_d));
      end else begin
        res[n[RES_IDX_W-1:0]] = mk_res(EV_PASS, 8'd0, KIND_IDENT, 16'd1, 16'd1);
      end
      n = n + 1'b1;
      mode_d  = MODE_IDLE;
      dig_d   = 1'b1;
      cl_d    = POS_ONE;
      cc_d    = POS_ONE;
      sl_d    = POS_ONE;
      sc_d    = POS_ONE;
      ol_d    = POS_ONE;
      oc_d    = POS_ONE;
      el_d    = POS_ONE;
      ec_d    = POS_ONE;
      depth_d = '0;
      err_d   = ERR_NONE;
    end

    if (n != '0) res[RES_IDX_W'(n - 1'b1)].last_result = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      dig_q   <= 1'b1;
      cl_q    <= POS_ONE;
      cc_q    <= POS_ONE;
      sl_q    <= POS_ONE;
      sc_q    <= POS_ONE;
      ol_q    <= POS_ONE;
      oc_q    <= POS_ONE;
      el_q    <= POS_ONE;
      ec_q    <= POS_ONE;
      depth_q <= '0;
      err_q   <= ERR_NONE;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      dig_q   <= dig_d;
      cl_q    <= cl_d;
      cc_q    <= cc_d;
      sl_q    <= sl_d;
      sc_q    <= sc_d;
      ol_q    <= ol_d;
      oc_q    <= oc_d;
      el_q    <= el_d;
      ec_q    <= ec_d;
      depth_q <= depth_d;
      err_q   <= err_d;
    end
  end

  assign push_o       = accept_i && (n != '0);
  assign bundle_o.cnt = n;
  assign bundle_o.res = res;

endmodule

/* hdl/stpc_queue.sv */
// Short queue of result bundles between the front lexer and the back serializer.
// Depends on stpc_pkg.
module stpc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  stpc_pkg::stpc_bundle_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output stpc_pkg::stpc_bundle_t head_o
);
  import stpc_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  stpc_bundle_t [QUEUE_DEPTH-1:0] mem_q;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

/* hdl/stpc_back.sv */
// Back serializer: walks the head bundle one result per cycle into the output register while not stalled.
// Depends on stpc_pkg.
module stpc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  stpc_pkg::stpc_bundle_t head_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output stpc_pkg::stpc_res_t    data_o
);
  import stpc_pkg::*;

  logic [RES_IDX_W-1:0] idx_q, idx_d;
  logic                 valid_q, valid_d;
  stpc_res_t            out_q;
  logic                 load, at_last;

  always_comb begin
    load    = !empty_i && (!valid_q || !stall_i);
    at_last = (RES_CNT_W'(idx_q) + 1'b1) == head_i.cnt;
    pop_o   = load && at_last;
    idx_d   = idx_q;
    if (load) idx_d = at_last ? '0 : idx_q + 1'b1;
    valid_d = load ? 1'b1 : (stall_i ? valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= head_i.res[idx_q];
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

/* hdl/sexpr_tokenizer_paren_check_top.sv */
// Top level of the s-expression tokenizer with paren check.
// Depends on stpc_pkg, stpc_front, stpc_queue and stpc_back.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o  | in_data_i  (stpc_in_t)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (stpc_res_t)
//
// A byte is taken in every cycle while the bundle queue has room; the lexer
// state updates in that same cycle.
// Results leave one per cycle from the output register while out_stall_i is low, so a
// byte that causes k results (k from 0 to 4) gives k output items in turn.
// Reset clears the lexer state, the queue and the output valid.
// out_stall_i holds the output register; the queue fills, then in_stall_o rises.
module sexpr_tokenizer_paren_check_top #(
  parameter int unsigned MAX_DEPTH = stpc_pkg::MAX_DEPTH_DEF,
  parameter int unsigned POS_WIDTH = stpc_pkg::POS_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stpc_pkg::stpc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stpc_pkg::stpc_res_t out_data_o
);
  import stpc_pkg::*;

  logic         accept, push, full, pop, empty;
  stpc_bundle_t push_data, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  stpc_front #(
    .MAX_DEPTH(MAX_DEPTH),
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (in_data_i),
    .push_o   (push),
    .bundle_o (push_data)
  );

  stpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  stpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

/* hdl/stpc_checker.sv */
// Port-level checks for the s-expression tokenizer, bound to the top level.
// Depends on stpc_pkg and sexpr_tokenizer_paren_check_top.
module stpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input stpc_pkg::stpc_res_t out_data_o
);
  import stpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == EV_PASS || out_data_o.event_res == EV_UNEXP ||
                    out_data_o.event_res == EV_MISSING ||
                    out_data_o.event_res == EV_OVERFLOW) |-> out_data_o.last_result)
    else $error("status event not marked last");

  a_pass_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == EV_PASS |->
      out_data_o.line_no == 16'd1 && out_data_o.column_no == 16'd1)
    else $error("pass status carries a position");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res != EV_CHAR |-> out_data_o.char_out == 8'd0)
    else $error("non-char event carries a character");

endmodule

bind sexpr_tokenizer_paren_check_top stpc_checker u_stpc_checker (.*);

/* tb/sv/sexpr_tokenizer_paren_check_top_tb.sv */
// Testbench for sexpr_tokenizer_paren_check_top: streams source text, predicts token and status
// items with a local lexer model and checks every result item in order.
// Depends on stpc_pkg and the tokenizer RTL.
module sexpr_tokenizer_paren_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stpc_pkg::*;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_TAIL   = 40;
  localparam int unsigned RANDOM_ITEMS = 140;
  localparam logic [15:0] POS_TOP      = 16'((32'd1 << POS_WIDTH_DEF) - 1);

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  stpc_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  stpc_res_t out_data;

  stpc_res_t  pending_events[$];
  stpc_res_t  byte_events[$];
  logic [7:0] text_buf[$];

  int errors_seen  = 0;
  int bytes_sent   = 0;
  int tx_gap_max   = 0;
  int rx_stall_max = 0;
  int rx_hold      = 0;
  int idle_cycles  = 0;

  stpc_mode_e  lx_mode;
  stpc_err_e   lx_err;
  logic        lx_digits;
  logic [7:0]  lx_depth;
  logic [15:0] cur_ln, cur_col, tok_ln, tok_col, open_ln, open_col, err_ln, err_col;

  sexpr_tokenizer_paren_check_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task lex_clear;
    lx_mode   = MODE_IDLE;
    lx_err    = ERR_NONE;
    lx_digits = 1'b1;
    lx_depth  = '0;
    cur_ln    = 16'd1;
    cur_col   = 16'd1;
    tok_ln    = 16'd1;
    tok_col   = 16'd1;
    open_ln   = 16'd1;
    open_col  = 16'd1;
    err_ln    = 16'd1;
    err_col   = 16'd1;
  endtask

  task add_event(input logic [2:0] ev, input logic [7:0] ch, input logic [1:0] kind,
                 input logic [15:0] ln, input logic [15:0] col);
    stpc_res_t r;
    r.event_res   = ev;
    r.char_out    = ch;
    r.token_kind  = kind;
    r.line_no     = ln;
    r.column_no   = col;
    r.last_result = 1'b0;
    if (byte_events.size() < MAX_RES) byte_events.insert(byte_events.size(), r);
  endtask

  task close_token(input logic [1:0] kind);
    add_event(EV_END, 8'h00, kind, tok_ln, tok_col);
  endtask

  task lex_byte(input logic [7:0] c, input logic eot);
    stpc_res_t r;
    byte_events.delete();
    if (lx_mode == MODE_ATOM && (is_blank(c) || c == CH_OPEN || c == CH_CLOSE)) begin
      close_token(lx_digits ? KIND_NUMBER : KIND_IDENT);
      lx_mode = MODE_IDLE;
    end
    case (lx_mode)
      MODE_ATOM: begin
        add_event(EV_CHAR, c, KIND_IDENT, tok_ln, tok_col);
        if (!is_num(c)) lx_digits = 1'b0;
      end
      MODE_STRING: begin
        if (c == CH_DQUOTE) begin
          close_token(KIND_STRING);
          lx_mode = MODE_IDLE;
        end else begin
          add_event(EV_CHAR, c, KIND_IDENT, tok_ln, tok_col);
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) lx_mode = MODE_IDLE;
      end
      default: begin
        if (!is_blank(c)) begin
          tok_ln  = cur_ln;
          tok_col = cur_col;
          if (c == CH_OPEN || c == CH_CLOSE) begin
            add_event(EV_CHAR, c, KIND_IDENT, tok_ln, tok_col);
            close_token(KIND_SYMBOL);
            if (lx_err == ERR_NONE) begin
              if (c == CH_OPEN) begin
                if (lx_depth >= MAX_DEPTH_DEF) begin
                  lx_err = ERR_DEPTH;
                  err_ln = cur_ln;
                  err_col = cur_col;
                end else begin
                  if (lx_depth == 0) begin
                    open_ln  = cur_ln;
                    open_col = cur_col;
                  end
                  lx_depth++;
                end
              end else if (lx_depth == 0) begin
                lx_err = ERR_CLOSE;
                err_ln = cur_ln;
                err_col = cur_col;
              end else begin
                lx_depth--;
              end
            end
          end else if (c == CH_SQUOTE) begin
            add_event(EV_CHAR, c, KIND_IDENT, tok_ln, tok_col);
            close_token(KIND_IDENT);
          end else if (c == CH_SEMI) begin
            lx_mode = MODE_COMMENT;
          end else if (c == CH_DQUOTE) begin
            lx_mode = MODE_STRING;
          end else begin
            lx_mode   = MODE_ATOM;
            lx_digits = is_num(c);
            add_event(EV_CHAR, c, KIND_IDENT, tok_ln, tok_col);
          end
        end
      end
    endcase
    if (c == CH_NL) begin
      if (cur_ln != POS_TOP) cur_ln++;
      cur_col = 16'd1;
    end else if (cur_col != POS_TOP) begin
      cur_col++;
    end
    if (eot) begin
      if (lx_mode == MODE_ATOM) close_token(lx_digits ? KIND_NUMBER : KIND_IDENT);
      else if (lx_mode == MODE_STRING) close_token(KIND_STRING);
      case (lx_err)
        ERR_CLOSE: add_event(EV_UNEXP, 8'h00, KIND_IDENT, err_ln, err_col);
        ERR_DEPTH: add_event(EV_OVERFLOW, 8'h00, KIND_IDENT, err_ln, err_col);
        default: begin
          if (lx_depth != 0) add_event(EV_MISSING, 8'h00, KIND_IDENT, open_ln, open_col);
          else add_event(EV_PASS, 8'h00, KIND_IDENT, 16'd1, 16'd1);
        end
      endcase
      lex_clear();
    end
    if (byte_events.size() > 0) begin
      r = byte_events[$];
      r.last_result = 1'b1;
      byte_events[byte_events.size() - 1] = r;
    end
    foreach (byte_events[i]) pending_events.insert(pending_events.size(), byte_events[i]);
  endtask

  task report(input string msg);
    errors_seen++;
    if (errors_seen <= 100) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: c, end_of_text: eot};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte(c, eot);
    bytes_sent++;
  endtask

  task send_text;
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // hold the sender until every predicted item has come back
  task wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task text_add(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_add(s[i]);
  endtask

  task put_blank;
    text_add($urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
  endtask

  task automatic put_atom;
    int len;
    logic numeric;
    logic [7:0] c;
    len = $urandom_range(1, 5);
    numeric = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if (numeric) begin
        c = 8'(CH_ZERO + $urandom_range(0, 9));
      end else begin
        c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == CH_OPEN || c == CH_CLOSE ||
               (i == 0 && (c == CH_SEMI || c == CH_DQUOTE || c == CH_SQUOTE)))
          c = 8'($urandom_range(0, 255));
      end
      text_add(c);
    end
  endtask

  task automatic put_quoted;
    int len;
    logic [7:0] c;
    len = $urandom_range(0, 4);
    text_add(CH_DQUOTE);
    repeat (len) begin
      c = ($urandom_range(0, 5) == 0) ? CH_NL : 8'($urandom_range(0, 255));
      while (c == CH_DQUOTE) c = 8'($urandom_range(0, 255));
      text_add(c);
    end
    text_add(CH_DQUOTE);
  endtask

  task automatic put_comment;
    int len;
    logic [7:0] c;
    len = $urandom_range(0, 4);
    text_add(CH_SEMI);
    repeat (len) begin
      c = 8'($urandom_range(0, 255));
      while (c == CH_NL) c = 8'($urandom_range(0, 255));
      text_add(c);
    end
    text_add(CH_NL);
  endtask

  task automatic build_sexpr(input int n_tok);
    int lvl;
    int pick;
    lvl = 0;
    repeat (n_tok) begin
      pick = $urandom_range(0, 9);
      if (pick < 2 && lvl < 6) begin
        text_add(CH_OPEN);
        lvl++;
      end else if (pick < 4 && lvl > 0) begin
        text_add(CH_CLOSE);
        lvl--;
      end else if (pick == 6) begin
        put_quoted();
      end else if (pick == 7) begin
        text_add(CH_SQUOTE);
      end else if (pick == 8) begin
        put_comment();
      end else begin
        put_atom();
      end
      if ($urandom_range(0, 2) != 0) put_blank();
    end
    repeat (lvl) text_add(CH_CLOSE);
  endtask

  task automatic build_noise;
    int len;
    logic [7:0] c;
    len = $urandom_range(4, 16);
    repeat (len) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE;
      text_add(c);
    end
  endtask

  task test_directed;
    tx_gap_max   = 13;
    rx_stall_max = 13;
    put_str("(ab 07 'q)");
    send_text();
    put_str("\"s\n");
    send_text();
    put_str(";x");
    send_text();
    put_str(")");
    send_text();
    put_str("( ");
    send_text();
    text_add(8'hFF);
    text_add(8'h00);
    text_add(CH_SPACE);
    text_add(CH_DQUOTE);
    text_add(8'h80);
    text_add(8'h7F);
    send_text();
    put_str("a;\"'");
    send_text();
    wait_drained();
  endtask

  task test_paren_overflow;
    tx_gap_max   = 3;
    rx_stall_max = 13;
    repeat (MAX_DEPTH_DEF + 1) text_add(CH_OPEN);
    text_add(CH_CLOSE);
    send_text();
    wait_drained();
  endtask

  task test_random_texts;
    int start_count;
    int style;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 13;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      style = $urandom_range(0, 9);
      if (style == 0) begin
        build_noise();
      end else begin
        build_sexpr($urandom_range(2, 8));
        if (style < 3) begin
          if ($urandom_range(0, 1)) text_buf.insert($urandom_range(0, text_buf.size()), CH_CLOSE);
          else text_buf.push_front(CH_OPEN);
        end
      end
      send_text();
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin : result_check
    stpc_res_t want;
    int hold;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          report($sformatf("unexpected item: event %0d", out_data.event_res));
        end else begin
          want = pending_events.pop_front();
          compare_field("event_res", 16'(out_data.event_res), 16'(want.event_res));
          compare_field("char_out", 16'(out_data.char_out), 16'(want.char_out));
          compare_field("token_kind", 16'(out_data.token_kind), 16'(want.token_kind));
          compare_field("line_no", out_data.line_no, want.line_no);
          compare_field("column_no", out_data.column_no, want.column_no);
          compare_field("last_result", 16'(out_data.last_result), 16'(want.last_result));
        end
        hold = $urandom_range(0, rx_stall_max);
        rx_hold = hold;
        if (hold > 0) out_stall <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold--;
        if (rx_hold == 0) out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    lex_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_paren_overflow();
    test_random_texts();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors_seen == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
hdl/stpc_pkg.sv
hdl/stpc_front.sv
hdl/stpc_queue.sv
hdl/stpc_back.sv
hdl/sexpr_tokenizer_paren_check_top.sv
hdl/stpc_checker.sv
tb/sv/sexpr_tokenizer_paren_check_top_tb.sv
